### hw/rtl/at_rlc_pkg.sv
//------------------------------------------------------------------------------
// AT response line classifier package
// Shared widths, operation and result codes, line patterns and the
// control structs between the top level and the event queue.
//------------------------------------------------------------------------------
`default_nettype none

package at_rlc_pkg;

	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int RES_W    = 2;
	localparam int CODE_W   = 3;
	localparam int HANDLE_W = 17;
	localparam int ACC_W    = 16;

	localparam logic [OP_W-1:0] OP_FEED  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_RESET = 2'd3;

	localparam logic [RES_W-1:0] RES_NONE  = 2'd0;
	localparam logic [RES_W-1:0] RES_OK    = 2'd1;
	localparam logic [RES_W-1:0] RES_ERROR = 2'd2;

	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	localparam logic [ACC_W-1:0]    HANDLE_MAX  = 16'hFFFF;
	localparam logic [HANDLE_W-1:0] HANDLE_NONE = 17'h1FFFF;

	// Patterns compared against the head of a line, six characters each,
	// left aligned and padded with spaces.
	localparam int NUM_PAT    = 9;
	localparam int PREFIX_MAX = 6;
	localparam int PAT_OK     = 0;
	localparam int PAT_ERROR  = 1;
	localparam int PAT_UDCP   = 2;
	localparam int PAT_TAG0   = 3;

	localparam logic [8*PREFIX_MAX-1:0] PAT_TEXT [NUM_PAT] = '{
		"OK    ", "ERROR ", "+UDCP:", "+UUWLE", "+UUWLD",
		"+UUNU ", "+UUND ", "+UUDPC", "+UUDPD"
	};
	localparam int PAT_LEN [NUM_PAT] = '{2, 5, 6, 6, 6, 5, 5, 6, 6};

	typedef struct packed {
		logic              push;
		logic              pop;
		logic              clear;
		logic [CODE_W-1:0] code;
	} fifo_cmd_t;

	typedef struct packed {
		logic              empty;
		logic [CODE_W-1:0] rd_data;
	} fifo_sts_t;

	// Per-pattern match of one line byte at a given position. Positions past
	// the end of a pattern always match.
	function automatic logic [NUM_PAT-1:0] pat_match(input logic [2:0] pos,
			input logic [BYTE_W-1:0] ch);
		logic [NUM_PAT-1:0] m;
		for (int k = 0; k < NUM_PAT; k++) begin
			if (int'(pos) >= PAT_LEN[k]) begin
				m[k] = 1'b1;
			end else begin
				m[k] = (ch == PAT_TEXT[k][8*PREFIX_MAX-1-8*int'(pos) -: 8]);
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/at_rlc_if.sv
//------------------------------------------------------------------------------
// AT response line classifier channels
// Valid/ready channels for the command items and the result items.
//------------------------------------------------------------------------------
`default_nettype none

interface at_rlc_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [at_rlc_pkg::OP_W-1:0]      operation;
	logic [at_rlc_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, operation, data_byte, input ready);
	modport sink (input valid, operation, data_byte, output ready);
endinterface

interface at_rlc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [at_rlc_pkg::RES_W-1:0]        line_result;
	logic                                event_valid;
	logic [at_rlc_pkg::CODE_W-1:0]       event_code;
	logic signed [at_rlc_pkg::HANDLE_W-1:0] peer_handle;

	modport source (output valid, line_result, event_valid, event_code, peer_handle,
		input ready);
	modport sink (input valid, line_result, event_valid, event_code, peer_handle,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/at_response_line_classifier_top.sv
//------------------------------------------------------------------------------
// AT response line classifier
// Collects modem response bytes into a line memory and classifies each line.
//------------------------------------------------------------------------------
// Every command item produces exactly one result item. Feeding a byte other
// than a line feed, clearing the events, resetting the line and popping an
// empty event queue go straight to the emit state. Popping a queued event
// passes through a state for the event queue read. A line feed on a stored
// line of F bytes walks the first min(F, 6) bytes of the line memory one byte
// per cycle through its single read port. A "+UDCP:" line longer than six
// bytes goes on to walk the bytes after the prefix, the digits and the byte
// that ends them. A new command is taken while the previous result still
// waits on the result channel; its own result then holds the block in its
// last cycle until the result register is free.
`default_nettype none

module at_response_line_classifier_top #(
	parameter int LINE_BYTES  = 128,
	parameter int EVENT_DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	at_rlc_cmd_if.sink   cmd,
	at_rlc_rsp_if.source rsp
);

	localparam int FW = $clog2(LINE_BYTES + 1);
	localparam int AW = $clog2(LINE_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_DIGIT,
		ST_POP,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [FW-1:0]                     fill_q;
	logic [FW-1:0]                     rd_idx_q;
	logic [at_rlc_pkg::NUM_PAT-1:0]    flags_q;
	logic [at_rlc_pkg::ACC_W-1:0]      acc_q;
	logic [at_rlc_pkg::HANDLE_W-1:0]   handle_q;
	logic [at_rlc_pkg::RES_W-1:0]      res_q;
	logic                              evv_q;
	logic [at_rlc_pkg::CODE_W-1:0]     code_q;
	logic                              out_valid_q;
	logic [at_rlc_pkg::RES_W-1:0]      out_res_q;
	logic                              out_evv_q;
	logic [at_rlc_pkg::CODE_W-1:0]     out_code_q;
	logic [at_rlc_pkg::HANDLE_W-1:0]   out_handle_q;

	logic                              cmd_fire;
	logic                              is_feed;
	logic                              is_lf;
	logic                              store_byte;
	logic [at_rlc_pkg::BYTE_W-1:0]     lr_rdata;
	logic [AW-1:0]                     lr_rd_addr;
	logic [FW-1:0]                     idx_inc;
	logic [FW-1:0]                     prefix_end;
	logic [at_rlc_pkg::NUM_PAT-1:0]    flags_nx;
	logic                              is_ok;
	logic                              is_err;
	logic                              is_udcp;
	logic                              tag_any;
	logic [at_rlc_pkg::CODE_W-1:0]     tag_code;
	logic                              is_digit;
	logic [at_rlc_pkg::ACC_W+3:0]      acc_sum;
	logic [at_rlc_pkg::ACC_W-1:0]      acc_sat;
	at_rlc_pkg::fifo_cmd_t             fifo_cmd;
	at_rlc_pkg::fifo_sts_t             fifo_sts;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign is_feed    = (cmd.operation == at_rlc_pkg::OP_FEED);
	assign is_lf      = (cmd.data_byte == at_rlc_pkg::CHAR_LF);
	assign store_byte = cmd_fire && is_feed && !is_lf
		&& (cmd.data_byte != at_rlc_pkg::CHAR_CR) && (fill_q < FW'(LINE_BYTES));

	assign idx_inc    = rd_idx_q + 1'b1;
	assign prefix_end = (fill_q < FW'(at_rlc_pkg::PREFIX_MAX)) ? fill_q
		: FW'(at_rlc_pkg::PREFIX_MAX);
	assign lr_rd_addr = (state_q == ST_IDLE) ? '0 : idx_inc[AW-1:0];

	at_rlc_ram #(
		.WIDTH(at_rlc_pkg::BYTE_W),
		.DEPTH(LINE_BYTES)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (store_byte),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(cmd.data_byte),
		.rd_en  (1'b1),
		.rd_addr(lr_rd_addr),
		.rd_data(lr_rdata)
	);

	always_comb begin
		flags_nx = flags_q & at_rlc_pkg::pat_match(rd_idx_q[2:0], lr_rdata);
		is_ok    = flags_nx[at_rlc_pkg::PAT_OK]
			&& (int'(fill_q) == at_rlc_pkg::PAT_LEN[at_rlc_pkg::PAT_OK]);
		is_err   = flags_nx[at_rlc_pkg::PAT_ERROR]
			&& (int'(fill_q) >= at_rlc_pkg::PAT_LEN[at_rlc_pkg::PAT_ERROR]);
		is_udcp  = flags_nx[at_rlc_pkg::PAT_UDCP]
			&& (int'(fill_q) >= at_rlc_pkg::PAT_LEN[at_rlc_pkg::PAT_UDCP]);
		tag_any  = 1'b0;
		tag_code = '0;
		for (int k = at_rlc_pkg::NUM_PAT - 1; k >= at_rlc_pkg::PAT_TAG0; k--) begin
			if (flags_nx[k] && int'(fill_q) >= at_rlc_pkg::PAT_LEN[k]) begin
				tag_any  = 1'b1;
				tag_code = at_rlc_pkg::CODE_W'(k - at_rlc_pkg::PAT_TAG0);
			end
		end
	end

	assign is_digit = (lr_rdata >= at_rlc_pkg::CHAR_ZERO)
		&& (lr_rdata <= at_rlc_pkg::CHAR_NINE);
	assign acc_sum  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
		+ (at_rlc_pkg::ACC_W+4)'(lr_rdata[3:0]);
	assign acc_sat  = (acc_sum > (at_rlc_pkg::ACC_W+4)'(at_rlc_pkg::HANDLE_MAX))
		? at_rlc_pkg::HANDLE_MAX : acc_sum[at_rlc_pkg::ACC_W-1:0];

	assign fifo_cmd.push  = (state_q == ST_PREFIX) && !(idx_inc < prefix_end)
		&& !is_ok && !is_err && !is_udcp && tag_any;
	assign fifo_cmd.pop   = cmd_fire && (cmd.operation == at_rlc_pkg::OP_POP)
		&& !fifo_sts.empty;
	assign fifo_cmd.clear = cmd_fire && ((cmd.operation == at_rlc_pkg::OP_CLEAR)
		|| (cmd.operation == at_rlc_pkg::OP_RESET));
	assign fifo_cmd.code  = tag_code;

	at_rlc_fifo #(
		.DEPTH(EVENT_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (fifo_cmd),
		.sts   (fifo_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			rd_idx_q     <= '0;
			flags_q      <= '0;
			acc_q        <= '0;
			handle_q     <= at_rlc_pkg::HANDLE_NONE;
			res_q        <= at_rlc_pkg::RES_NONE;
			evv_q        <= 1'b0;
			code_q       <= '0;
			out_valid_q  <= 1'b0;
			out_res_q    <= at_rlc_pkg::RES_NONE;
			out_evv_q    <= 1'b0;
			out_code_q   <= '0;
			out_handle_q <= at_rlc_pkg::HANDLE_NONE;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						res_q   <= at_rlc_pkg::RES_NONE;
						evv_q   <= 1'b0;
						code_q  <= '0;
						state_q <= ST_EMIT;
						case (cmd.operation)
							at_rlc_pkg::OP_FEED: begin
								if (is_lf && fill_q != '0) begin
									rd_idx_q <= '0;
									flags_q  <= '1;
									state_q  <= ST_PREFIX;
								end else if (store_byte) begin
									fill_q <= fill_q + 1'b1;
								end
							end
							at_rlc_pkg::OP_POP: begin
								if (!fifo_sts.empty) begin
									state_q <= ST_POP;
								end
							end
							at_rlc_pkg::OP_RESET: begin
								fill_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PREFIX: begin
					flags_q  <= flags_nx;
					rd_idx_q <= idx_inc;
					if (!(idx_inc < prefix_end)) begin
						fill_q  <= '0;
						state_q <= ST_EMIT;
						if (is_ok) begin
							res_q <= at_rlc_pkg::RES_OK;
						end else if (is_err) begin
							res_q <= at_rlc_pkg::RES_ERROR;
						end else if (is_udcp) begin
							if (fill_q > FW'(at_rlc_pkg::PREFIX_MAX)) begin
								acc_q   <= '0;
								fill_q  <= fill_q;
								state_q <= ST_DIGIT;
							end else begin
								handle_q <= '0;
							end
						end
					end
				end
				ST_DIGIT: begin
					rd_idx_q <= idx_inc;
					if (is_digit && idx_inc < fill_q) begin
						acc_q <= acc_sat;
					end else begin
						handle_q <= is_digit ? {1'b0, acc_sat} : {1'b0, acc_q};
						fill_q   <= '0;
						state_q  <= ST_EMIT;
					end
				end
				ST_POP: begin
					evv_q   <= 1'b1;
					code_q  <= fifo_sts.rd_data;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_res_q    <= res_q;
						out_evv_q    <= evv_q;
						out_code_q   <= code_q;
						out_handle_q <= handle_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.line_result = out_res_q;
	assign rsp.event_valid = out_evv_q;
	assign rsp.event_code  = out_code_q;
	assign rsp.peer_handle = out_handle_q;

	a_event_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.event_valid && rsp.line_result != at_rlc_pkg::RES_NONE))
		else $error("event and line result reported in the same item");
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.event_valid) |-> rsp.event_code == '0)
		else $error("event code set without a popped event");
	a_walk_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREFIX || state_q == ST_DIGIT) |-> rd_idx_q < fill_q)
		else $error("line walk reads past the stored line");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(LINE_BYTES))
		else $error("line fill exceeds the line memory");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> state_q != ST_IDLE)
		else $error("command accepted without producing work");

endmodule

`default_nettype wire

### hw/rtl/at_rlc_ram.sv
//------------------------------------------------------------------------------
// AT response line classifier RAM
// Generic single-write, single-read memory with a registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module at_rlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/at_rlc_fifo.sv
//------------------------------------------------------------------------------
// AT response line classifier event queue
// Circular queue of event codes held in a RAM, with head and count.
//------------------------------------------------------------------------------
`default_nettype none

module at_rlc_fifo #(
	parameter int DEPTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire at_rlc_pkg::fifo_cmd_t cmd,
	output at_rlc_pkg::fifo_sts_t      sts
);

	localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW:0]   tail_sum;
	logic [HW-1:0] tail;
	logic [HW-1:0] head_inc;
	logic          full;
	logic          wr_en;
	logic [at_rlc_pkg::CODE_W-1:0] rd_data;

	assign full     = (count_q == CW'(DEPTH));
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail     = (tail_sum >= (CW+1)'(DEPTH)) ? HW'(tail_sum - (CW+1)'(DEPTH))
		: HW'(tail_sum);
	assign head_inc = ((CW+1)'(head_q) + 1'b1 == (CW+1)'(DEPTH)) ? '0 : HW'(head_q + 1'b1);
	assign wr_en    = cmd.push && !full && !cmd.clear;

	at_rlc_ram #(
		.WIDTH(at_rlc_pkg::CODE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail),
		.wr_data(cmd.code),
		.rd_en  (cmd.pop),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop && count_q != '0) begin
			head_q  <= head_inc;
			count_q <= count_q - 1'b1;
		end
	end

	assign sts.empty   = (count_q == '0);
	assign sts.rd_data = rd_data;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("event queue count exceeds its depth");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(head_q) < (CW+1)'(DEPTH))
		else $error("event queue head out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop issued on an empty event queue");

endmodule

`default_nettype wire
